/* rtl/b2y420_pkg.sv */
`timescale 1ns / 1ps

package b2y420_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int CFG_W = 13;
  localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // One line store entry: red, green, blue pair sums, 9 bits each
  localparam int PSUM_W = 9;
  localparam int ENTRY_W = 3 * PSUM_W;

  // Luma: ((66 R + 129 G + 25 B + 128) >> 8) + 16
  typedef logic [15:0] luma_acc_t;
  localparam luma_acc_t LY_R    = 16'd66;
  localparam luma_acc_t LY_G    = 16'd129;
  localparam luma_acc_t LY_B    = 16'd25;
  localparam luma_acc_t LY_RND  = 16'd128;
  localparam logic [7:0] LY_OFS = 8'd16;

  // Chroma: floor((a R + b G + c B + 128) / 256) + 128
  typedef logic signed [17:0] chroma_acc_t;
  localparam chroma_acc_t CB_R  = 18'sd38;
  localparam chroma_acc_t CB_G  = 18'sd74;
  localparam chroma_acc_t CB_B  = 18'sd112;
  localparam chroma_acc_t CR_R  = 18'sd112;
  localparam chroma_acc_t CR_G  = 18'sd94;
  localparam chroma_acc_t CR_B  = 18'sd18;
  localparam chroma_acc_t C_RND = 18'sd128;
  // adding 128 * 256 turns the floor shift plus offset into a bit select
  localparam chroma_acc_t C_BIAS = 18'sd32768;

endpackage

/* rtl/b2y420_ram.sv */
`timescale 1ns / 1ps

module b2y420_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port; rdata holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/bgr_to_ycbcr420_converter.sv */
`timescale 1ns / 1ps
// BGR to YCbCr 4:2:0 converter, BT.601 limited range.
// A request passes stage 1, stage 2 and the output register before its result is valid.
// Throughput: one pixel per clock while out_tready does not stall the pipe; the
// line store takes one write or one read per pixel pair and its registered read sets the first pipe stage.
// Reset (rst_n low, synchronous): counters, held pixel and pipe valids clear,
// line_width = 640, frame_height = 480; the line store is not cleared.

module bgr_to_ycbcr420_converter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // blue[7:0], green[15:8], red[23:16]

  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // luma[7:0], blue_difference[15:8],
                                                  // red_difference[23:16]
  output logic                        out_tuser,  // chroma_valid
  output logic                        out_tlast,  // frame_last

  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [b2y420_pkg::CFG_W-1:0] cfg_data
);

  import b2y420_pkg::*;

  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = AW + 1;
  localparam int RW    = $clog2(MAX_HEIGHT);

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] line_width_r, frame_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LINE_WIDTH:   line_width_r   <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // even, at least 2, at most the bound
  logic [31:0] w_full, h_full;
  logic [CW:0] w_eff;
  logic [RW:0] h_eff;

  always_comb begin
    w_full = {19'd0, line_width_r[CFG_W-1:1], 1'b0};
    if (w_full < 32'd2) begin
      w_full = 32'd2;
    end else if (w_full > 32'(MAX_WIDTH)) begin
      w_full = 32'(MAX_WIDTH) & ~32'd1;
    end
    h_full = {19'd0, frame_height_r[CFG_W-1:1], 1'b0};
    if (h_full < 32'd2) begin
      h_full = 32'd2;
    end else if (h_full > 32'(MAX_HEIGHT)) begin
      h_full = 32'(MAX_HEIGHT) & ~32'd1;
    end
  end

  assign w_eff = w_full[CW:0];
  assign h_eff = h_full[RW:0];

  // ---------------- pipe handshake ----------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_adv, s2_adv, s1_adv, in_acc;

  assign out_adv   = !out_v_r || out_tready;
  assign s2_adv    = !s2_v_r || out_adv;
  assign s1_adv    = !s1_v_r || s2_adv;
  assign in_tready = s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------- stage 0: counters, pair sums, luma ----------------
  logic [7:0] in_b, in_g, in_r;
  assign in_b = in_tdata[7:0];
  assign in_g = in_tdata[15:8];
  assign in_r = in_tdata[23:16];

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [23:0]   held_r;
  logic          col_end, row_end, last_s0, odd_col, odd_row;
  logic [PSUM_W-1:0] sum_r, sum_g, sum_b;
  luma_acc_t     luma_acc;
  logic [7:0]    luma_s0;

  assign odd_col = col_r[0];
  assign odd_row = row_r[0];
  assign col_end = ({1'b0, col_r} + 1'b1) >= w_eff;
  assign row_end = ({1'b0, row_r} + 1'b1) >= h_eff;
  assign last_s0 = col_end && row_end;

  always_comb begin
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : row_r + 1'b1;
    end
  end

  assign sum_r = {1'b0, held_r[23:16]} + {1'b0, in_r};
  assign sum_g = {1'b0, held_r[15:8]}  + {1'b0, in_g};
  assign sum_b = {1'b0, held_r[7:0]}   + {1'b0, in_b};

  assign luma_acc = LY_R * {8'd0, in_r} + LY_G * {8'd0, in_g}
                  + LY_B * {8'd0, in_b} + LY_RND;
  assign luma_s0  = luma_acc[15:8] + LY_OFS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (!odd_col) begin
        held_r <= in_tdata;
      end
    end
  end

  // ---------------- line store ----------------
  // even rows write the pair sums, odd rows read them back for the block
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  assign ram_addr  = col_r[AW:1];
  assign ram_we    = in_acc && odd_col && !odd_row;
  assign ram_re    = in_acc && odd_col && odd_row;
  assign ram_wdata = {sum_r, sum_g, sum_b};

  b2y420_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // ---------------- stage 1: block averages ----------------
  logic [PSUM_W-1:0] s1_sr_r, s1_sg_r, s1_sb_r;
  logic [7:0]        s1_luma_r;
  logic              s1_chroma_r, s1_last_r;
  logic [PSUM_W:0]   blk_r, blk_g, blk_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sr_r     <= sum_r;
      s1_sg_r     <= sum_g;
      s1_sb_r     <= sum_b;
      s1_luma_r   <= luma_s0;
      s1_chroma_r <= odd_col && odd_row;
      s1_last_r   <= last_s0;
    end
  end

  assign blk_r = {1'b0, s1_sr_r} + {1'b0, ram_rdata[3*PSUM_W-1:2*PSUM_W]};
  assign blk_g = {1'b0, s1_sg_r} + {1'b0, ram_rdata[2*PSUM_W-1:PSUM_W]};
  assign blk_b = {1'b0, s1_sb_r} + {1'b0, ram_rdata[PSUM_W-1:0]};

  // ---------------- stage 2: chroma products ----------------
  logic [7:0] s2_ar_r, s2_ag_r, s2_ab_r, s2_luma_r;
  logic       s2_chroma_r, s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_v_r) begin
      s2_ar_r     <= blk_r[PSUM_W:2];
      s2_ag_r     <= blk_g[PSUM_W:2];
      s2_ab_r     <= blk_b[PSUM_W:2];
      s2_luma_r   <= s1_luma_r;
      s2_chroma_r <= s1_chroma_r;
      s2_last_r   <= s1_last_r;
    end
  end

  chroma_acc_t ar_x, ag_x, ab_x, cb_x, cr_x;
  logic [7:0]  cb_s2, cr_s2;

  assign ar_x = chroma_acc_t'({10'd0, s2_ar_r});
  assign ag_x = chroma_acc_t'({10'd0, s2_ag_r});
  assign ab_x = chroma_acc_t'({10'd0, s2_ab_r});
  assign cb_x = CB_B * ab_x - CB_R * ar_x - CB_G * ag_x + C_RND + C_BIAS;
  assign cr_x = CR_R * ar_x - CR_G * ag_x - CR_B * ab_x + C_RND + C_BIAS;
  // no chroma on this pixel: both differences read as the mid code
  assign cb_s2 = s2_chroma_r ? cb_x[15:8] : 8'd128;
  assign cr_s2 = s2_chroma_r ? cr_x[15:8] : 8'd128;

  // ---------------- output register ----------------
  logic [23:0] out_data_r;
  logic        out_user_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s2_v_r) begin
      out_data_r <= {cr_s2, cb_s2, s2_luma_r};
      out_user_r <= s2_chroma_r;
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // ---------------- assertions ----------------
  // a pixel never both writes and reads the line store
  a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("line store written and read in one cycle");

  // an empty pipe always takes a request
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_v_r && !s2_v_r && !out_v_r) |-> in_tready)
    else $error("empty pipe not ready");

  // luma stays in the limited range
  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] >= 8'd16 && out_tdata[7:0] <= 8'd235))
    else $error("luma out of range");

  // pixels without chroma carry the mid code
  a_no_chroma_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[15:8] == 8'd128 && out_tdata[23:16] == 8'd128))
    else $error("chroma code on pixel without chroma");

endmodule
